FILE: sv/ppp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the path position block.
// Depends on nothing; every other file imports it.
package ppp_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORD_N = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int CYC_W = 16 + $clog2(MAX_SEGMENTS);
  localparam int STEP_W = $clog2(ATAN_ENTRIES);

  localparam int HALF_TURN = 180;
  localparam int Q16_ONE = 65536;
  localparam int CORDIC_K = 39797;
  localparam int FULL_Q = 2 * HALF_TURN * Q16_ONE;
  localparam int HALF_Q = HALF_TURN * Q16_ONE;
  localparam int QUARTER_Q = HALF_Q / 2;

  localparam int DIV_NW = 48;
  localparam int DIV_DW = 25;
  localparam int DIV_CW = $clog2(DIV_NW + 1);

  localparam logic [1:0] FN_APPEND = 2'd0;
  localparam logic [1:0] FN_QUERY = 2'd1;
  localparam logic [1:0] FN_CLEAR = 2'd2;

  typedef enum logic [1:0] {OP_APPEND, OP_QUERY, OP_CLEAR, OP_NOP} op_t;

  typedef enum logic [1:0] {ST_OK, ST_FULL, ST_ZERO, ST_EMPTY} st_t;

  typedef enum logic [4:0] {
    S_IDLE, S_EXEC, S_MOD, S_MODW, S_WALK,
    S_LM1, S_LM2, S_LDIV, S_LWAIT,
    S_AM1, S_ADIV, S_AWAIT, S_ARED, S_ARWAIT, S_AFOLD, S_ACOR, S_AM, S_ASUM,
    S_DONE
  } bstate_t;

  typedef struct packed {
    op_t         op;
    logic [12:0] sx;
    logic [12:0] sy;
    logic [12:0] ex;
    logic [12:0] ey;
    logic [15:0] dur;
    logic        arc;
    logic [11:0] rad;
    logic [31:0] qtime;
  } item_t;

  typedef struct packed {
    logic [12:0] sx;
    logic [12:0] sy;
    logic [12:0] ex;
    logic [12:0] ey;
    logic [15:0] dur;
    logic        arc;
    logic [11:0] rad;
  } seg_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quo;
    logic [DIV_DW-1:0] rem;
  } div_rsp_t;

  function automatic logic [21:0] atan_q16(input logic [STEP_W-1:0] i);
    logic [21:0] v;
    case (i)
      5'd0: v = 22'd2949120;
      5'd1: v = 22'd1740967;
      5'd2: v = 22'd919879;
      5'd3: v = 22'd466945;
      5'd4: v = 22'd234379;
      5'd5: v = 22'd117304;
      5'd6: v = 22'd58666;
      5'd7: v = 22'd29335;
      5'd8: v = 22'd14668;
      5'd9: v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [13:0] sat14(input logic signed [47:0] v);
    logic signed [13:0] r;
    if (v > 48'sd8191) r = 14'sd8191;
    else if (v < -48'sd8192) r = -14'sd8192;
    else r = v[13:0];
    return r;
  endfunction

endpackage

FILE: sv/piecewise_path_position.sv
`timescale 1ns / 1ps
// Path position block top: front end, item queue, back end.
// Append, clear and unused codes go straight to the result; a query's time is set by the
// bit-serial divider run three times (line) or twice (arc), a one-segment-per-cycle walk,
// a six-step angle reduction and CORDIC.
// One item in the back end at a time; three more wait in the front register and queue.
// Synchronous active-low reset empties the table and queue; results cannot be stalled.
module piecewise_path_position import ppp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_func,
  input  logic [12:0]        in_start_x,
  input  logic [12:0]        in_start_y,
  input  logic [12:0]        in_end_x,
  input  logic [12:0]        in_end_y,
  input  logic [15:0]        in_duration,
  input  logic               in_is_arc,
  input  logic [11:0]        in_radius,
  input  logic [31:0]        in_query_time,
  output logic               out_valid,
  output logic signed [13:0] out_pos_x,
  output logic signed [13:0] out_pos_y,
  output logic [1:0]         out_status
);

  logic  q_full, q_empty, push, pop;
  item_t push_item, q_item;

  ppp_front u_front (
    .clk (clk),
    .rst_n (rst_n),
    .start (start),
    .busy (busy),
    .in_func (in_func),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x (in_end_x),
    .in_end_y (in_end_y),
    .in_duration (in_duration),
    .in_is_arc (in_is_arc),
    .in_radius (in_radius),
    .in_query_time (in_query_time),
    .q_full (q_full),
    .push (push),
    .push_item (push_item)
  );

  ppp_fifo u_fifo (
    .clk (clk),
    .rst_n (rst_n),
    .push (push),
    .push_item (push_item),
    .pop (pop),
    .full (q_full),
    .empty (q_empty),
    .rd_item (q_item)
  );

  ppp_back u_back (
    .clk (clk),
    .rst_n (rst_n),
    .q_empty (q_empty),
    .q_item (q_item),
    .pop (pop),
    .out_valid (out_valid),
    .out_pos_x (out_pos_x),
    .out_pos_y (out_pos_y),
    .out_status (out_status)
  );

endmodule

FILE: sv/ppp_front.sv
`timescale 1ns / 1ps
// Front end: takes items, classifies the function code, hands items to the queue.
// Depends on ppp_pkg.
module ppp_front import ppp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [12:0] in_start_x,
  input  logic [12:0] in_start_y,
  input  logic [12:0] in_end_x,
  input  logic [12:0] in_end_y,
  input  logic [15:0] in_duration,
  input  logic        in_is_arc,
  input  logic [11:0] in_radius,
  input  logic [31:0] in_query_time,
  input  logic        q_full,
  output logic        push,
  output item_t       push_item
);

  logic  hold_vld_r;
  item_t hold_r;
  item_t item_nxt;
  logic  accept;

  assign busy = hold_vld_r & q_full;
  assign accept = start & ~busy;
  assign push = hold_vld_r & ~q_full;
  assign push_item = hold_r;

  always_comb begin
    item_nxt.sx = in_start_x;
    item_nxt.sy = in_start_y;
    item_nxt.ex = in_end_x;
    item_nxt.ey = in_end_y;
    item_nxt.dur = in_duration;
    item_nxt.arc = in_is_arc;
    item_nxt.rad = in_radius;
    item_nxt.qtime = in_query_time;
    case (in_func)
      FN_APPEND: item_nxt.op = OP_APPEND;
      FN_QUERY: item_nxt.op = OP_QUERY;
      FN_CLEAR: item_nxt.op = OP_CLEAR;
      default: item_nxt.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else if (accept) begin
      hold_vld_r <= 1'b1;
    end else if (push) begin
      hold_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= item_nxt;
    end
  end

endmodule

FILE: sv/ppp_fifo.sv
`timescale 1ns / 1ps
// Two-entry item queue between front end and back end.
// Depends on ppp_pkg.
module ppp_fifo import ppp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  empty,
  output item_t rd_item
);

  item_t      mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rd_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      if (push && !pop) cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule

FILE: sv/ppp_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider, one quotient bit per cycle, shared by the back end.
// Depends on ppp_pkg.
module ppp_div import ppp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_NW-1:0] q_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_DW:0]   rem_sh;
  logic              ge;
  logic [DIV_DW:0]   rem_sub;

  assign rem_sh = {rem_r, q_r[DIV_NW-1]};
  assign ge = (rem_sh >= {1'b0, den_r});
  assign rem_sub = rem_sh - {1'b0, den_r};

  assign rsp.done = done_r;
  assign rsp.quo = q_r;
  assign rsp.rem = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r <= DIV_CW'(DIV_NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r <= req.num;
      rem_r <= '0;
      den_r <= req.den;
    end else if (busy_r) begin
      q_r <= {q_r[DIV_NW-2:0], ge};
      rem_r <= ge ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
    end
  end

endmodule

FILE: sv/ppp_back.sv
`timescale 1ns / 1ps
// Back end: segment table, time reduction, segment walk, line and arc interpolation.
// Depends on ppp_pkg and uses ppp_div.
module ppp_back import ppp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  item_t              q_item,
  output logic               pop,
  output logic               out_valid,
  output logic signed [13:0] out_pos_x,
  output logic signed [13:0] out_pos_y,
  output logic [1:0]         out_status
);

  bstate_t state_r, state_nxt;
  item_t   cur_r;
  seg_t    seg_mem [MAX_SEGMENTS];
  seg_t    seg_r;
  seg_t    rd_seg;
  logic [CNT_W-1:0] count_r;
  logic [CYC_W-1:0] cyc_r;
  logic [CNT_W-1:0] wcnt_r;
  logic [CYC_W-1:0] t_r;
  logic axis_r, neg_r, flip_r;
  logic signed [47:0] acc_r;
  logic signed [25:0] a_r;
  logic signed [19:0] x_r, y_r;
  logic [STEP_W-1:0] i_r;
  logic signed [13:0] res_x_r, res_y_r;
  st_t res_st_r;

  div_req_t dreq;
  div_rsp_t drsp;

  logic signed [12:0] s_ax, e_ax;
  logic signed [13:0] diff_l, diff_a;
  logic [47:0] mag;
  logic signed [47:0] qs;
  logic signed [47:0] lin_q;
  logic [47:0] red_m;
  logic [47:0] red_step;
  logic [DIV_DW-1:0] red_a;
  logic signed [19:0] c_ax;
  logic signed [47:0] arc_sum, arc_tr;
  logic signed [19:0] dx, dy;
  logic signed [25:0] at;

  localparam logic signed [25:0] QUARTER_S = 26'(QUARTER_Q);
  localparam logic signed [25:0] HALF_S = 26'(HALF_Q);
  localparam logic signed [25:0] FULL_S = 26'(FULL_Q);
  localparam logic [STEP_W-1:0] RED_TOP = STEP_W'(5);

  ppp_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (dreq),
    .rsp (drsp)
  );

  assign rd_seg = seg_mem[wcnt_r[IDX_W-1:0]];
  assign s_ax = axis_r ? $signed(seg_r.sy) : $signed(seg_r.sx);
  assign e_ax = axis_r ? $signed(seg_r.ey) : $signed(seg_r.ex);
  assign diff_l = $signed({e_ax[12], e_ax}) - $signed({s_ax[12], s_ax});
  assign diff_a = $signed({seg_r.ey[12], seg_r.ey}) - $signed({seg_r.ex[12], seg_r.ex});
  assign mag = acc_r[47] ? 48'(-acc_r) : 48'(acc_r);
  assign qs = neg_r ? -$signed(drsp.quo) : $signed(drsp.quo);
  assign lin_q = qs;
  assign red_m = 48'(FULL_Q) << i_r;
  assign red_step = ($unsigned(acc_r) >= red_m) ? $unsigned(acc_r) - red_m : $unsigned(acc_r);
  assign red_a = (neg_r && red_step != '0) ? DIV_DW'(FULL_Q) - red_step[DIV_DW-1:0]
                                           : red_step[DIV_DW-1:0];
  assign c_ax = axis_r ? (flip_r ? -y_r : y_r) : (flip_r ? -x_r : x_r);
  assign arc_sum = {{19{s_ax[12]}}, s_ax, 16'b0} + acc_r;
  assign arc_tr = arc_sum[47] ? ((arc_sum + 48'sd65535) >>> 16) : (arc_sum >>> 16);
  assign dx = y_r >>> i_r;
  assign dy = x_r >>> i_r;
  assign at = $signed({4'b0, atan_q16(i_r)});

  assign out_pos_x = res_x_r;
  assign out_pos_y = res_y_r;
  assign out_status = res_st_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (!q_empty) state_nxt = S_EXEC;
      S_EXEC: begin
        if (cur_r.op == OP_QUERY && count_r != '0 && cyc_r != '0) state_nxt = S_MOD;
        else state_nxt = S_DONE;
      end
      S_MOD: state_nxt = S_MODW;
      S_MODW: if (drsp.done) state_nxt = S_WALK;
      S_WALK: begin
        if (wcnt_r == count_r) state_nxt = S_DONE;
        else if (t_r <= CYC_W'(rd_seg.dur)) state_nxt = rd_seg.arc ? S_AM1 : S_LM1;
      end
      S_LM1: state_nxt = S_LM2;
      S_LM2: state_nxt = S_LDIV;
      S_LDIV: state_nxt = S_LWAIT;
      S_LWAIT: if (drsp.done) state_nxt = axis_r ? S_DONE : S_LM1;
      S_AM1: state_nxt = S_ADIV;
      S_ADIV: state_nxt = S_AWAIT;
      S_AWAIT: if (drsp.done) state_nxt = S_ARED;
      S_ARED: state_nxt = S_ARWAIT;
      S_ARWAIT: if (i_r == '0) state_nxt = S_AFOLD;
      S_AFOLD: state_nxt = S_ACOR;
      S_ACOR: if (i_r == STEP_W'(CORD_N - 1)) state_nxt = S_AM;
      S_AM: state_nxt = S_ASUM;
      S_ASUM: state_nxt = axis_r ? S_DONE : S_AM;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    out_valid = 1'b0;
    dreq.start = 1'b0;
    dreq.num = mag;
    dreq.den = DIV_DW'(seg_r.dur);
    case (state_r)
      S_IDLE: pop = ~q_empty;
      S_MOD: begin
        dreq.start = 1'b1;
        dreq.num = DIV_NW'(cur_r.qtime);
        dreq.den = DIV_DW'(cyc_r);
      end
      S_LDIV: dreq.start = 1'b1;
      S_ADIV: begin
        dreq.start = 1'b1;
        dreq.num = {mag[DIV_NW-17:0], 16'b0};
      end
      S_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      cyc_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_EXEC) begin
        if (cur_r.op == OP_CLEAR) begin
          count_r <= '0;
          cyc_r <= '0;
        end else if (cur_r.op == OP_APPEND && cur_r.dur != 16'd0
                     && count_r < CNT_W'(MAX_SEGMENTS)) begin
          count_r <= count_r + 1'b1;
          cyc_r <= cyc_r + CYC_W'(cur_r.dur);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EXEC && cur_r.op == OP_APPEND && cur_r.dur != 16'd0
        && count_r < CNT_W'(MAX_SEGMENTS)) begin
      seg_mem[count_r[IDX_W-1:0]] <= '{sx: cur_r.sx, sy: cur_r.sy, ex: cur_r.ex,
                                       ey: cur_r.ey, dur: cur_r.dur, arc: cur_r.arc,
                                       rad: cur_r.rad};
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (!q_empty) cur_r <= q_item;
      S_EXEC: begin
        res_x_r <= '0;
        res_y_r <= '0;
        res_st_r <= ST_OK;
        case (cur_r.op)
          OP_APPEND: begin
            if (cur_r.dur == 16'd0) res_st_r <= ST_ZERO;
            else if (count_r >= CNT_W'(MAX_SEGMENTS)) res_st_r <= ST_FULL;
          end
          OP_QUERY: if (count_r == '0 || cyc_r == '0) res_st_r <= ST_EMPTY;
          default: ;
        endcase
      end
      S_MODW: begin
        wcnt_r <= '0;
        t_r <= drsp.rem[CYC_W-1:0];
      end
      S_WALK: begin
        if (wcnt_r != count_r) begin
          if (t_r > CYC_W'(rd_seg.dur)) begin
            t_r <= t_r - CYC_W'(rd_seg.dur);
            wcnt_r <= wcnt_r + 1'b1;
          end else begin
            seg_r <= rd_seg;
            axis_r <= 1'b0;
          end
        end
      end
      S_LM1: acc_r <= s_ax * $signed({1'b0, seg_r.dur});
      S_LM2: acc_r <= acc_r + diff_l * $signed({1'b0, t_r[15:0]});
      S_LDIV: neg_r <= acc_r[47];
      S_LWAIT: begin
        if (drsp.done) begin
          if (axis_r) res_y_r <= sat14(lin_q);
          else res_x_r <= sat14(lin_q);
          axis_r <= 1'b1;
        end
      end
      S_AM1: acc_r <= diff_a * $signed({1'b0, t_r[15:0]});
      S_ADIV: neg_r <= acc_r[47];
      S_AWAIT: if (drsp.done) acc_r <= {{19{seg_r.ex[12]}}, seg_r.ex, 16'b0} + qs;
      S_ARED: begin
        neg_r <= acc_r[47];
        acc_r <= $signed(mag);
        i_r <= RED_TOP;
      end
      S_ARWAIT: begin
        acc_r <= $signed(red_step);
        i_r <= i_r - 1'b1;
        if (i_r == '0) a_r <= $signed({1'b0, red_a});
      end
      S_AFOLD: begin
        x_r <= 20'(CORDIC_K);
        y_r <= '0;
        i_r <= '0;
        if (a_r > QUARTER_S && a_r <= 3 * QUARTER_S) begin
          a_r <= a_r - HALF_S;
          flip_r <= 1'b1;
        end else begin
          flip_r <= 1'b0;
          if (a_r > 3 * QUARTER_S) a_r <= a_r - FULL_S;
        end
      end
      S_ACOR: begin
        if (a_r >= 0) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          a_r <= a_r - at;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          a_r <= a_r + at;
        end
        i_r <= i_r + 1'b1;
      end
      S_AM: acc_r <= $signed({1'b0, seg_r.rad}) * c_ax;
      S_ASUM: begin
        if (axis_r) res_y_r <= sat14(arc_tr);
        else res_x_r <= sat14(arc_tr);
        axis_r <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

FILE: sim/piecewise_path_position_test.sv
`timescale 1ns / 1ps
// Self-checking bench for piecewise_path_position: directed table, then random items.
// Depends on ppp_pkg and the piecewise_path_position RTL.
module piecewise_path_position_test;
  import ppp_pkg::*;

  typedef struct {
    logic [1:0]  func;
    logic [12:0] sx, sy, ex, ey;
    logic [15:0] dur;
    logic        arc;
    logic [11:0] rad;
    logic [31:0] qt;
  } path_item_t;

  typedef struct {
    logic [13:0] px, py;
    logic [1:0]  st;
  } position_t;

  typedef struct {
    path_item_t it;
    bit         typed;
    position_t  res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_func = '0;
  logic [12:0] in_start_x = '0, in_start_y = '0, in_end_x = '0, in_end_y = '0;
  logic [15:0] in_duration = '0;
  logic in_is_arc = 1'b0;
  logic [11:0] in_radius = '0;
  logic [31:0] in_query_time = '0;
  logic out_valid;
  logic signed [13:0] out_pos_x, out_pos_y;
  logic [1:0] out_status;

  piecewise_path_position dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  path_item_t seg_tab[MAX_SEGMENTS];
  int unsigned seg_cnt;
  longint unsigned cyc_len;
  position_t pending_pos[$];
  int errors = 0;
  int table_errors;
  longint cycles = 0;

  localparam longint ATAN_TAB[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp14(longint v);
    if (v > 8191) return 8191;
    if (v < -8192) return -8192;
    return v;
  endfunction

  function automatic void rotate_deg(input longint ang, output longint c, output longint s);
    longint fullq, halfq, qq, a, x, y, dx, dy;
    bit neg;
    fullq = 360 * 65536;
    halfq = 180 * 65536;
    qq = halfq / 2;
    a = ang % fullq;
    neg = 0;
    x = 39797;
    y = 0;
    if (a < 0) a += fullq;
    if (a > qq && a <= 3 * qq) begin
      a -= halfq;
      neg = 1;
    end else if (a > 3 * qq) a -= fullq;
    for (int i = 0; i < CORD_N; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (a >= 0) begin
        x -= dx; y += dy; a -= ATAN_TAB[i];
      end else begin
        x += dx; y -= dy; a += ATAN_TAB[i];
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic position_t predict_position(input path_item_t it);
    position_t r;
    longint px, py, d, t, sx, sy, ex, ey, ang, c, s;
    px = 0; py = 0;
    r.st = ST_OK;
    if (it.func == FN_APPEND) begin
      if (it.dur == 0) r.st = ST_ZERO;
      else if (seg_cnt >= MAX_SEGMENTS) r.st = ST_FULL;
      else begin
        seg_tab[seg_cnt] = it;
        seg_cnt++;
        cyc_len += it.dur;
      end
    end else if (it.func == FN_QUERY) begin
      if (seg_cnt == 0 || cyc_len == 0) r.st = ST_EMPTY;
      else begin
        t = longint'(it.qt) % longint'(cyc_len);
        for (int i = 0; i < seg_cnt; i++) begin
          d = seg_tab[i].dur;
          if (t > d) begin
            t -= d;
            continue;
          end
          sx = longint'($signed(seg_tab[i].sx));
          sy = longint'($signed(seg_tab[i].sy));
          ex = longint'($signed(seg_tab[i].ex));
          ey = longint'($signed(seg_tab[i].ey));
          if (seg_tab[i].arc) begin
            ang = ex * 65536 + ((ey - ex) * t * 65536) / d;
            rotate_deg(ang, c, s);
            px = (sx * 65536 + longint'(seg_tab[i].rad) * c) / 65536;
            py = (sy * 65536 + longint'(seg_tab[i].rad) * s) / 65536;
          end else begin
            px = (sx * d + (ex - sx) * t) / d;
            py = (sy * d + (ey - sy) * t) / d;
          end
          break;
        end
        px = clamp14(px);
        py = clamp14(py);
      end
    end else if (it.func == FN_CLEAR) begin
      seg_cnt = 0;
      cyc_len = 0;
    end
    r.px = px[13:0];
    r.py = py[13:0];
    return r;
  endfunction

  function automatic path_item_t mk(logic [1:0] f, int sx, int sy, int ex, int ey,
                                    int dur, bit arc, int rad, logic [31:0] qt);
    path_item_t it;
    it.func = f; it.sx = 13'(sx); it.sy = 13'(sy); it.ex = 13'(ex); it.ey = 13'(ey);
    it.dur = 16'(dur); it.arc = arc; it.rad = 12'(rad); it.qt = qt;
    return it;
  endfunction

  function automatic path_item_t rand_item(bit well_formed);
    path_item_t it;
    int k;
    it.sx = 13'($urandom); it.sy = 13'($urandom);
    it.ex = 13'($urandom); it.ey = 13'($urandom);
    it.rad = 12'($urandom); it.arc = 1'($urandom_range(0, 1));
    it.qt = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3000);
    k = $urandom_range(0, 99);
    it.dur = (k < 5) ? 16'd0 : (k < 15) ? 16'($urandom) : 16'($urandom_range(1, 300));
    if (it.arc && $urandom_range(0, 1)) begin
      it.ex = 13'($urandom_range(0, 720) - 360);
      it.ey = 13'($urandom_range(0, 720) - 360);
    end
    k = $urandom_range(0, 99);
    if (well_formed) it.func = (k < 40) ? FN_APPEND : (k < 95) ? FN_QUERY : FN_CLEAR;
    else it.func = (k < 30) ? FN_APPEND : (k < 60) ? FN_QUERY : (k < 85) ? FN_CLEAR : OP_NOP;
    return it;
  endfunction

  row_t rows[$];
  bit idle_on;

  task automatic send_item(input path_item_t it, input bit typed, input position_t res);
    position_t p;
    while (idle_on && $urandom_range(0, 99) < 14) begin
      start <= 1'b0;
      @(posedge clk);
    end
    p = predict_position(it);
    if (typed) begin
      if (p.px !== res.px) begin
        $error("table pos_x expected %0d got %0d", $signed(res.px), $signed(p.px));
        table_errors++;
      end
      if (p.py !== res.py) begin
        $error("table pos_y expected %0d got %0d", $signed(res.py), $signed(p.py));
        table_errors++;
      end
      if (p.st !== res.st) begin
        $error("table status expected %0d got %0d", res.st, p.st);
        table_errors++;
      end
    end
    pending_pos.insert(pending_pos.size(), p);
    start <= 1'b1;
    in_func <= it.func;
    in_start_x <= it.sx; in_start_y <= it.sy; in_end_x <= it.ex; in_end_y <= it.ey;
    in_duration <= it.dur; in_is_arc <= it.arc; in_radius <= it.rad;
    in_query_time <= it.qt;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (pending_pos.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        position_t e;
        e = pending_pos.pop_front();
        if (out_pos_x !== e.px) begin
          $error("pos_x expected %0d got %0d", $signed(e.px), out_pos_x);
          errors++;
        end
        if (out_pos_y !== e.py) begin
          $error("pos_y expected %0d got %0d", $signed(e.py), out_pos_y);
          errors++;
        end
        if (out_status !== e.st) begin
          $error("status expected %0d got %0d", e.st, out_status);
          errors++;
        end
      end
    end
  end

  function automatic row_t row(path_item_t it, bit typed, int px, int py, st_t st);
    row_t r;
    r.it = it; r.typed = typed;
    r.res.px = 14'(px); r.res.py = 14'(py); r.res.st = st;
    return r;
  endfunction

  task automatic add_row(input row_t r);
    rows.insert(rows.size(), r);
  endtask

  initial begin
    path_item_t it;
    position_t none;
    int n;
    table_errors = 0; seg_cnt = 0; cyc_len = 0;
    none = '{default: '0};
    idle_on = 1;
    add_row(row(mk(FN_QUERY, 0, 0, 0, 0, 1, 0, 0, 5), 1, 0, 0, ST_EMPTY));
    add_row(row(mk(OP_NOP, -1, -1, -1, -1, 65535, 1, 4095, '1), 1, 0, 0, ST_OK));
    add_row(row(mk(FN_APPEND, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, ST_ZERO));
    add_row(row(mk(FN_APPEND, -4096, -4096, 4095, 4095, 100, 0, 0, 0), 1, 0, 0,
                ST_OK));
    add_row(row(mk(FN_QUERY, 0, 0, 0, 0, 0, 0, 0, 0), 1, -4096, -4096, ST_OK));
    add_row(row(mk(FN_QUERY, 0, 0, 0, 0, 0, 0, 0, 100), 1, -4096, -4096, ST_OK));
    add_row(row(mk(FN_QUERY, 0, 0, 0, 0, 0, 0, 0, 50), 0, 0, 0, ST_OK));
    add_row(row(mk(FN_APPEND, 4095, -4096, 0, 360, 65535, 1, 4095, 0), 1, 0, 0,
                ST_OK));
    add_row(row(mk(FN_QUERY, 0, 0, 0, 0, 0, 0, 0, 100), 0, 0, 0, ST_OK));
    add_row(row(mk(FN_QUERY, 0, 0, 0, 0, 0, 0, 0, 30000), 0, 0, 0, ST_OK));
    add_row(row(mk(FN_QUERY, 0, 0, 0, 0, 0, 0, 0, '1), 0, 0, 0, ST_OK));
    for (int i = 0; i < 14; i++)
      add_row(row(mk(FN_APPEND, i, -i, 90 * i, -90 * i, 1 + i, 1'(i % 2), 100, 0), 1,
                  0, 0, ST_OK));
    add_row(row(mk(FN_APPEND, 0, 0, 0, 0, 7, 0, 0, 0), 1, 0, 0, ST_FULL));
    add_row(row(mk(FN_APPEND, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, ST_ZERO));
    add_row(row(mk(FN_QUERY, 0, 0, 0, 0, 0, 0, 0, 65600), 0, 0, 0, ST_OK));
    add_row(row(mk(FN_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, ST_OK));
    add_row(row(mk(FN_QUERY, 0, 0, 0, 0, 0, 0, 0, 9), 1, 0, 0, ST_EMPTY));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].res);

    n = 0;
    while (n < 550) begin
      if (n == 150) idle_on = 0;
      if (n == 300) idle_on = 1;
      if (n == 400) begin
        start <= 1'b0;
        @(posedge clk);
        while (pending_pos.size() != 0) @(posedge clk);
      end
      it = rand_item($urandom_range(0, 99) < 85);
      send_item(it, 0, none);
      if (it.func != OP_NOP) n++;
    end

    start <= 1'b0;
    while (pending_pos.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && table_errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
